// ===== src/bcc_pkg.sv =====
// shared types, constants and decode helpers for the bytecode cpu core
`timescale 1ns / 1ps
`default_nettype none
package bcc_pkg;

  // memory map
  localparam int MEM_AW = 12;
  localparam logic [11:0] LOAD_BASE    = 12'd512;
  localparam logic [11:0] STACK_BASE   = 12'd3744;
  localparam logic [11:0] DISPLAY_BASE = 12'd3840;
  localparam logic [11:0] FONT_BASE    = 12'd0;
  localparam int FONT_LEN = 80;

  // hex font, glyph 0 in the top bits
  localparam logic [FONT_LEN*8-1:0] FONT_ROM = {
    40'hF0909090F0, 40'h2060202070, 40'hF010F080F0, 40'hF010F010F0,
    40'h9090F01010, 40'hF080F010F0, 40'hF080F090F0, 40'hF010204040,
    40'hF090F090F0, 40'hF090F010F0, 40'hF090F09090, 40'hE090E090E0,
    40'hF0808080F0, 40'hE0909090E0, 40'hF080F080F0, 40'hF080F08080};

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_EXEC  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // special instructions and fx sub-codes
  localparam logic [15:0] INS_CLS = 16'h00E0;
  localparam logic [15:0] INS_RET = 16'h00EE;
  localparam logic [7:0] EX_SKP  = 8'h9E;
  localparam logic [7:0] EX_SKNP = 8'hA1;
  localparam logic [7:0] FX_GDT  = 8'h07;
  localparam logic [7:0] FX_KEY  = 8'h0A;
  localparam logic [7:0] FX_SDT  = 8'h15;
  localparam logic [7:0] FX_SST  = 8'h18;
  localparam logic [7:0] FX_ADDI = 8'h1E;
  localparam logic [7:0] FX_FONT = 8'h29;
  localparam logic [7:0] FX_BCD  = 8'h33;
  localparam logic [7:0] FX_DUMP = 8'h55;
  localparam logic [7:0] FX_LOAD = 8'h65;

  // instruction classes seen by the sequencer
  localparam logic [3:0] K_SIMPLE = 4'd0;
  localparam logic [3:0] K_FLAG   = 4'd1;
  localparam logic [3:0] K_CLS    = 4'd2;
  localparam logic [3:0] K_RET    = 4'd3;
  localparam logic [3:0] K_CALL   = 4'd4;
  localparam logic [3:0] K_DRAW   = 4'd5;
  localparam logic [3:0] K_BCD    = 4'd6;
  localparam logic [3:0] K_DUMP   = 4'd7;
  localparam logic [3:0] K_LOAD   = 4'd8;
  localparam logic [3:0] K_BAD    = 4'd9;
  localparam logic [3:0] K_WAIT   = 4'd10;

  // memory address selects
  localparam logic [3:0] MA_IN   = 4'd0;
  localparam logic [3:0] MA_PC   = 4'd1;
  localparam logic [3:0] MA_PC1  = 4'd2;
  localparam logic [3:0] MA_SP   = 4'd3;
  localparam logic [3:0] MA_SP1  = 4'd4;
  localparam logic [3:0] MA_ICNT = 4'd5;
  localparam logic [3:0] MA_PIX  = 4'd6;
  localparam logic [3:0] MA_DISP = 4'd7;
  localparam logic [3:0] MA_CNT  = 4'd8;

  // memory write data selects
  localparam logic [2:0] MW_IN   = 3'd0;
  localparam logic [2:0] MW_FILL = 3'd1;
  localparam logic [2:0] MW_ZERO = 3'd2;
  localparam logic [2:0] MW_PCHI = 3'd3;
  localparam logic [2:0] MW_PCLO = 3'd4;
  localparam logic [2:0] MW_BCD  = 3'd5;
  localparam logic [2:0] MW_VQ   = 3'd6;
  localparam logic [2:0] MW_XOR  = 3'd7;

  // register file selects
  localparam logic [1:0] VA_X   = 2'd0;
  localparam logic [1:0] VA_F   = 2'd1;
  localparam logic [1:0] VA_CNT = 2'd2;
  localparam logic [1:0] VR_X   = 2'd0;
  localparam logic [1:0] VR_Y   = 2'd1;
  localparam logic [1:0] VR_CNT = 2'd2;
  localparam logic [2:0] VW_FLAG = 3'd0;
  localparam logic [2:0] VW_MEMQ = 3'd1;
  localparam logic [2:0] VW_COLL = 3'd2;
  localparam logic [2:0] VW_ZERO = 3'd3;

  // pc, sp and counter operations
  localparam logic [2:0] PC_HOLD = 3'd0;
  localparam logic [2:0] PC_EXEC = 3'd1;
  localparam logic [2:0] PC_NEXT = 3'd2;
  localparam logic [2:0] PC_RET  = 3'd3;
  localparam logic [2:0] PC_NNN  = 3'd4;
  localparam logic [1:0] SP_HOLD = 2'd0;
  localparam logic [1:0] SP_DEC2 = 2'd1;
  localparam logic [1:0] SP_INC2 = 2'd2;
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_CLR  = 2'd1;
  localparam logic [1:0] CNT_INC  = 2'd2;

  typedef struct packed {
    logic       in_load;
    logic       out_load;
    logic [1:0] res_status;
    logic       rd_load;
    logic       ir_hi;
    logic       ir_lo;
    logic       va_load;
    logic       vb_load;
    logic       exec;
    logic       mem_we;
    logic [3:0] mem_asel;
    logic [2:0] mem_wsel;
    logic       vr_we;
    logic [1:0] vr_wasel;
    logic [2:0] vr_wsel;
    logic [1:0] vr_rsel;
    logic [2:0] pc_op;
    logic [1:0] sp_op;
    logic [1:0] cnt_op;
    logic       tmp_load;
    logic       tick;
    logic       coll_clr;
    logic       coll_upd;
    logic       row_load;
    logic       bit_next;
  } cmd_t;

  typedef struct packed {
    logic [15:0] ir;
    logic [11:0] cnt;
    logic        key_valid;
    logic        row_msb;
    logic        clip;
    logic        bit_last;
  } stat_t;

  // classify a fetched instruction
  function automatic logic [3:0] instr_kind(input logic [15:0] ir, input logic kv);
    logic [3:0] k;
    k = K_SIMPLE;
    case (ir[15:12])
      4'h0: begin
        if (ir == INS_CLS) k = K_CLS;
        else if (ir == INS_RET) k = K_RET;
        else k = K_BAD;
      end
      4'h2: k = K_CALL;
      4'h8: begin
        case (ir[3:0])
          4'h0, 4'h1, 4'h2, 4'h3: k = K_SIMPLE;
          4'h4, 4'h5, 4'h6, 4'h7, 4'hE: k = K_FLAG;
          default: k = K_BAD;
        endcase
      end
      4'hD: k = K_DRAW;
      4'hE: begin
        if (ir[7:0] == EX_SKP || ir[7:0] == EX_SKNP) k = K_SIMPLE;
        else k = K_BAD;
      end
      4'hF: begin
        case (ir[7:0])
          FX_GDT, FX_SDT, FX_SST, FX_ADDI, FX_FONT: k = K_SIMPLE;
          FX_KEY: k = kv ? K_SIMPLE : K_WAIT;
          FX_BCD: k = K_BCD;
          FX_DUMP: k = K_DUMP;
          FX_LOAD: k = K_LOAD;
          default: k = K_BAD;
        endcase
      end
      default: k = K_SIMPLE;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== src/bcc_datapath.sv =====
// datapath: memory, register file, pc/sp/index/timers, alu and result register
`timescale 1ns / 1ps
`default_nettype none
module bcc_datapath
  import bcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [55:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  output logic [39:0]      m_tdata,
  output logic [1:0]       m_tuser
);

  // latched input word
  logic [1:0]  in_op;
  logic [11:0] in_addr;
  logic [7:0]  in_wd;
  logic [7:0]  in_rnd;
  logic [15:0] in_keys;
  logic        in_kv;
  logic [3:0]  in_kc;

  // architectural state
  logic [11:0] pc;
  logic [11:0] sp;
  logic [15:0] ireg;
  logic [7:0]  dt;
  logic [7:0]  st;

  // sequencing registers
  logic [15:0] ir;
  logic [7:0]  va;
  logic [7:0]  vb;
  logic [11:0] cnt;
  logic [2:0]  bcnt;
  logic [7:0]  row;
  logic        coll;
  logic [7:0]  tmp;
  logic [7:0]  rd_r;
  logic        taken;

  // memories
  logic [7:0] mem [4096];
  logic [7:0] mem_q;
  logic [7:0] vreg [16];
  logic [7:0] vq;

  // result register
  logic [1:0]  o_status;
  logic [7:0]  o_rd;
  logic [15:0] o_word;
  logic [11:0] o_pc;
  logic        o_taken;
  logic        o_sound;

  logic [3:0]  fx;
  logic [3:0]  fy;
  logic [3:0]  fn;
  logic [7:0]  nn;
  logic [11:0] nnn;
  assign fx  = ir[11:8];
  assign fy  = ir[7:4];
  assign fn  = ir[3:0];
  assign nn  = ir[7:0];
  assign nnn = ir[11:0];

  logic [11:0] pc2;
  logic [11:0] pc4;
  assign pc2 = pc + 12'd2;
  assign pc4 = pc + 12'd4;

  // combinational execute results
  logic [11:0] pc_exec;
  logic        wvx;
  logic [7:0]  vx_val;
  logic        i_we;
  logic [15:0] i_val;
  logic        dt_we;
  logic        st_we;
  logic        take;
  logic        held;
  logic [8:0]  sum;
  logic        flag;
  assign held = (va[7:4] == 4'd0) && in_keys[va[3:0]];
  assign sum  = {1'b0, va} + {1'b0, vb};

  always_comb begin
    pc_exec = pc2;
    wvx     = 1'b0;
    vx_val  = 8'd0;
    i_we    = 1'b0;
    i_val   = ireg;
    dt_we   = 1'b0;
    st_we   = 1'b0;
    take    = 1'b0;
    case (ir[15:12])
      4'h1: pc_exec = nnn;
      4'h3: pc_exec = (va == nn) ? pc4 : pc2;
      4'h4: pc_exec = (va != nn) ? pc4 : pc2;
      4'h5: pc_exec = (va == vb) ? pc4 : pc2;
      4'h6: begin
        wvx = 1'b1;
        vx_val = nn;
      end
      4'h7: begin
        wvx = 1'b1;
        vx_val = va + nn;
      end
      4'h8: begin
        wvx = 1'b1;
        case (fn)
          4'h0: vx_val = vb;
          4'h1: vx_val = va | vb;
          4'h2: vx_val = va & vb;
          4'h3: vx_val = va ^ vb;
          4'h4: vx_val = sum[7:0];
          4'h5: vx_val = va - vb;
          4'h6: vx_val = {1'b0, va[7:1]};
          4'h7: vx_val = vb - va;
          4'hE: vx_val = {va[6:0], 1'b0};
          default: wvx = 1'b0;
        endcase
      end
      4'h9: pc_exec = (va != vb) ? pc4 : pc2;
      4'hA: begin
        i_we = 1'b1;
        i_val = {4'd0, nnn};
      end
      4'hB: pc_exec = {4'd0, va} + nnn;
      4'hC: begin
        wvx = 1'b1;
        vx_val = in_rnd & nn;
      end
      4'hE: begin
        if (nn == EX_SKP) pc_exec = held ? pc4 : pc2;
        else pc_exec = held ? pc2 : pc4;
      end
      4'hF: begin
        case (nn)
          FX_GDT: begin
            wvx = 1'b1;
            vx_val = dt;
          end
          FX_KEY: begin
            wvx = 1'b1;
            vx_val = {4'd0, in_kc};
            take = 1'b1;
          end
          FX_SDT: dt_we = 1'b1;
          FX_SST: st_we = 1'b1;
          FX_ADDI: begin
            i_we = 1'b1;
            i_val = ireg + {8'd0, va};
          end
          FX_FONT: begin
            i_we = 1'b1;
            i_val = {4'd0, FONT_BASE} + {12'd0, va[3:0]} * 16'd5;
          end
          default: i_we = 1'b0;
        endcase
      end
      default: pc_exec = pc2;
    endcase
  end

  // flag value for the 8xy arithmetic group
  always_comb begin
    case (fn)
      4'h4: flag = sum[8];
      4'h5: flag = (va >= vb);
      4'h6: flag = va[0];
      4'h7: flag = (vb >= va);
      4'hE: flag = va[7];
      default: flag = 1'b0;
    endcase
  end

  // bcd digits of vx
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] tprod;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [7:0]  bcd_digit;
  always_comb begin
    if (va >= 8'd200) begin
      hund = 2'd2;
      rem = 7'(va - 8'd200);
    end else if (va >= 8'd100) begin
      hund = 2'd1;
      rem = 7'(va - 8'd100);
    end else begin
      hund = 2'd0;
      rem = va[6:0];
    end
    tprod = {8'd0, rem} * 15'd205;
    tens  = tprod[14:11];
    ones  = 4'(rem - {tens, 3'd0} - {2'd0, tens, 1'b0});
    case (cnt[1:0])
      2'd0: bcd_digit = {6'd0, hund};
      2'd1: bcd_digit = {4'd0, tens};
      default: bcd_digit = {4'd0, ones};
    endcase
  end

  // sprite pixel address
  logic [5:0]  px;
  logic [8:0]  pysum;
  logic [11:0] pix_addr;
  logic [7:0]  bitmask;
  logic        hit;
  assign px       = va[5:0] + {3'd0, bcnt};
  assign pysum    = {1'b0, vb} + {5'd0, cnt[3:0]};
  assign pix_addr = DISPLAY_BASE + {4'd0, pysum[4:0], px[5:3]};
  assign bitmask  = 8'h80 >> px[2:0];
  assign hit      = |(mem_q & bitmask);

  // font fill during the clearing pass
  logic [11:0] fofs;
  logic [7:0]  fill_byte;
  assign fofs = cnt - FONT_BASE;
  always_comb begin
    if (fofs < 12'(FONT_LEN))
      fill_byte = FONT_ROM[(FONT_LEN - 1 - int'(fofs[6:0])) * 8 +: 8];
    else
      fill_byte = 8'd0;
  end

  // memory address and write data
  logic [11:0] mem_addr;
  logic [7:0]  mem_wd;
  always_comb begin
    case (cmd.mem_asel)
      MA_IN:   mem_addr = in_addr;
      MA_PC:   mem_addr = pc;
      MA_PC1:  mem_addr = pc + 12'd1;
      MA_SP:   mem_addr = sp;
      MA_SP1:  mem_addr = sp + 12'd1;
      MA_ICNT: mem_addr = ireg[11:0] + cnt;
      MA_PIX:  mem_addr = pix_addr;
      MA_DISP: mem_addr = DISPLAY_BASE + {4'd0, cnt[7:0]};
      MA_CNT:  mem_addr = cnt;
      default: mem_addr = cnt;
    endcase
    case (cmd.mem_wsel)
      MW_IN:   mem_wd = in_wd;
      MW_FILL: mem_wd = fill_byte;
      MW_ZERO: mem_wd = 8'd0;
      MW_PCHI: mem_wd = {4'd0, pc[11:8]};
      MW_PCLO: mem_wd = pc[7:0];
      MW_BCD:  mem_wd = bcd_digit;
      MW_VQ:   mem_wd = vq;
      MW_XOR:  mem_wd = mem_q ^ bitmask;
      default: mem_wd = 8'd0;
    endcase
  end

  // main memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[mem_addr] <= mem_wd;
    mem_q <= mem[mem_addr];
  end

  // register file selects
  logic [3:0] vr_raddr;
  logic [3:0] vr_waddr;
  logic [7:0] vr_wd;
  logic       vr_we;
  always_comb begin
    case (cmd.vr_rsel)
      VR_X:    vr_raddr = (ir[15:12] == 4'hB) ? 4'd0 : fx;
      VR_Y:    vr_raddr = fy;
      default: vr_raddr = cnt[3:0];
    endcase
    case (cmd.vr_wasel)
      VA_F:    vr_waddr = 4'hF;
      VA_CNT:  vr_waddr = cnt[3:0];
      default: vr_waddr = fx;
    endcase
    case (cmd.vr_wsel)
      VW_FLAG: vr_wd = {7'd0, flag};
      VW_MEMQ: vr_wd = mem_q;
      VW_COLL: vr_wd = {7'd0, coll};
      default: vr_wd = 8'd0;
    endcase
    vr_we = cmd.vr_we;
    if (cmd.exec && wvx) begin
      vr_we = 1'b1;
      vr_waddr = fx;
      vr_wd = vx_val;
    end
  end

  // register file, registered read
  always_ff @(posedge clk) begin
    if (vr_we) vreg[vr_waddr] <= vr_wd;
    vq <= vreg[vr_raddr];
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= LOAD_BASE;
      sp   <= STACK_BASE;
      ireg <= 16'd0;
      dt   <= 8'd0;
      st   <= 8'd0;
      cnt  <= 12'd0;
    end else begin
      case (cmd.pc_op)
        PC_EXEC: pc <= pc_exec;
        PC_NEXT: pc <= pc2;
        PC_RET:  pc <= {tmp[3:0], mem_q} + 12'd2;
        PC_NNN:  pc <= nnn;
        default: pc <= pc;
      endcase
      case (cmd.sp_op)
        SP_DEC2: sp <= sp - 12'd2;
        SP_INC2: sp <= sp + 12'd2;
        default: sp <= sp;
      endcase
      if (cmd.exec && i_we) ireg <= i_val;
      if (cmd.tick) begin
        if (dt != 8'd0) dt <= dt - 8'd1;
        if (st != 8'd0) st <= st - 8'd1;
      end else begin
        if (cmd.exec && dt_we) dt <= va;
        if (cmd.exec && st_we) st <= va;
      end
      case (cmd.cnt_op)
        CNT_CLR: cnt <= 12'd0;
        CNT_INC: cnt <= cnt + 12'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      in_addr <= s_tdata[11:0];
      in_wd   <= s_tdata[19:12];
      in_rnd  <= s_tdata[27:20];
      in_keys <= s_tdata[43:28];
      in_kv   <= s_tdata[44];
      in_kc   <= s_tdata[48:45];
      in_op   <= s_tuser;
      rd_r    <= 8'd0;
      taken   <= 1'b0;
    end else begin
      if (cmd.rd_load) rd_r <= mem_q;
      if (cmd.exec && take) taken <= 1'b1;
    end
    if (cmd.ir_hi) ir[15:8] <= mem_q;
    if (cmd.ir_lo) ir[7:0] <= mem_q;
    if (cmd.va_load) va <= vq;
    if (cmd.vb_load) vb <= vq;
    if (cmd.tmp_load) tmp <= mem_q;
    if (cmd.coll_clr) coll <= 1'b0;
    else if (cmd.coll_upd && hit) coll <= 1'b1;
    if (cmd.row_load) begin
      row  <= mem_q;
      bcnt <= 3'd0;
    end else if (cmd.bit_next) begin
      row  <= {row[6:0], 1'b0};
      bcnt <= bcnt + 3'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status <= cmd.res_status;
      o_rd     <= rd_r;
      o_word   <= (in_op == OP_EXEC) ? ir : 16'd0;
      o_pc     <= pc;
      o_taken  <= taken;
      o_sound  <= (st != 8'd0);
    end
  end

  assign m_tdata = {2'd0, o_sound, o_taken, o_pc, o_word, o_rd};
  assign m_tuser = o_status;

  // status toward the sequencer
  assign stat.ir        = ir;
  assign stat.cnt       = cnt;
  assign stat.key_valid = in_kv;
  assign stat.row_msb   = row[7];
  assign stat.clip      = (pysum[8:5] != 4'd0);
  assign stat.bit_last  = (bcnt == 3'd7);

endmodule
`default_nettype wire

// ===== src/bcc_controller.sv =====
// sequencer state machine for the bytecode cpu core
`timescale 1ns / 1ps
`default_nettype none
module bcc_controller
  import bcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [1:0] s_tuser,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  input  wire stat_t      stat,
  output cmd_t            cmd
);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_WR    = 5'd2;
  localparam logic [4:0] S_RD    = 5'd3;
  localparam logic [4:0] S_RD2   = 5'd4;
  localparam logic [4:0] S_TICK  = 5'd5;
  localparam logic [4:0] S_F1    = 5'd6;
  localparam logic [4:0] S_F2    = 5'd7;
  localparam logic [4:0] S_F3    = 5'd8;
  localparam logic [4:0] S_F4    = 5'd9;
  localparam logic [4:0] S_F5    = 5'd10;
  localparam logic [4:0] S_DEC   = 5'd11;
  localparam logic [4:0] S_EXF   = 5'd12;
  localparam logic [4:0] S_CLS   = 5'd13;
  localparam logic [4:0] S_RET1  = 5'd14;
  localparam logic [4:0] S_RET2  = 5'd15;
  localparam logic [4:0] S_RET3  = 5'd16;
  localparam logic [4:0] S_RET4  = 5'd17;
  localparam logic [4:0] S_CALL1 = 5'd18;
  localparam logic [4:0] S_CALL2 = 5'd19;
  localparam logic [4:0] S_BCD   = 5'd20;
  localparam logic [4:0] S_DMPA  = 5'd21;
  localparam logic [4:0] S_DMPB  = 5'd22;
  localparam logic [4:0] S_LDA   = 5'd23;
  localparam logic [4:0] S_LDB   = 5'd24;
  localparam logic [4:0] S_DR0   = 5'd25;
  localparam logic [4:0] S_DRR   = 5'd26;
  localparam logic [4:0] S_DRQ   = 5'd27;
  localparam logic [4:0] S_DRB   = 5'd28;
  localparam logic [4:0] S_DRW   = 5'd29;
  localparam logic [4:0] S_DRF   = 5'd30;
  localparam logic [4:0] S_FIN   = 5'd31;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [1:0] res;
  logic [1:0] res_next;
  logic [3:0] kind;
  logic       row_done;

  assign kind     = instr_kind(stat.ir, stat.key_valid);
  assign row_done = (stat.cnt[3:0] == (stat.ir[3:0] - 4'd1));
  assign s_tready = (state == S_IDLE);

  // next state and command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    res_next   = res;
    case (state)
      S_CLR: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_asel = MA_CNT;
        cmd.mem_wsel = MW_FILL;
        cmd.vr_we    = 1'b1;
        cmd.vr_wasel = VA_CNT;
        cmd.vr_wsel  = VW_ZERO;
        cmd.cnt_op   = CNT_INC;
        if (stat.cnt == 12'hFFF) begin
          cmd.cnt_op = CNT_CLR;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.in_load = 1'b1;
          res_next    = ST_DONE;
          case (s_tuser)
            OP_WRITE: state_next = S_WR;
            OP_READ:  state_next = S_RD;
            OP_EXEC:  state_next = S_F1;
            default:  state_next = S_TICK;
          endcase
        end
      end
      S_WR: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_asel = MA_IN;
        cmd.mem_wsel = MW_IN;
        state_next   = S_FIN;
      end
      S_RD: begin
        cmd.mem_asel = MA_IN;
        state_next   = S_RD2;
      end
      S_RD2: begin
        cmd.rd_load = 1'b1;
        state_next  = S_FIN;
      end
      S_TICK: begin
        cmd.tick   = 1'b1;
        state_next = S_FIN;
      end
      // fetch and operand read
      S_F1: begin
        cmd.mem_asel = MA_PC;
        state_next   = S_F2;
      end
      S_F2: begin
        cmd.ir_hi    = 1'b1;
        cmd.mem_asel = MA_PC1;
        state_next   = S_F3;
      end
      S_F3: begin
        cmd.ir_lo   = 1'b1;
        cmd.vr_rsel = VR_X;
        state_next  = S_F4;
      end
      S_F4: begin
        cmd.va_load = 1'b1;
        cmd.vr_rsel = VR_Y;
        state_next  = S_F5;
      end
      S_F5: begin
        cmd.vb_load = 1'b1;
        state_next  = S_DEC;
      end
      S_DEC: begin
        cmd.cnt_op = CNT_CLR;
        case (kind)
          K_SIMPLE: begin
            cmd.exec   = 1'b1;
            cmd.pc_op  = PC_EXEC;
            state_next = S_FIN;
          end
          K_FLAG: begin
            cmd.exec   = 1'b1;
            cmd.pc_op  = PC_EXEC;
            state_next = S_EXF;
          end
          K_CLS:  state_next = S_CLS;
          K_RET:  state_next = S_RET1;
          K_CALL: state_next = S_CALL1;
          K_DRAW: state_next = S_DR0;
          K_BCD:  state_next = S_BCD;
          K_DUMP: state_next = S_DMPA;
          K_LOAD: state_next = S_LDA;
          K_WAIT: begin
            res_next   = ST_WAIT;
            state_next = S_FIN;
          end
          default: begin
            res_next   = ST_BAD;
            state_next = S_FIN;
          end
        endcase
      end
      S_EXF: begin
        cmd.vr_we    = 1'b1;
        cmd.vr_wasel = VA_F;
        cmd.vr_wsel  = VW_FLAG;
        state_next   = S_FIN;
      end
      // display clear
      S_CLS: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_asel = MA_DISP;
        cmd.mem_wsel = MW_ZERO;
        cmd.cnt_op   = CNT_INC;
        if (stat.cnt[7:0] == 8'hFF) begin
          cmd.pc_op  = PC_NEXT;
          state_next = S_FIN;
        end
      end
      // return from subroutine
      S_RET1: begin
        cmd.sp_op  = SP_DEC2;
        state_next = S_RET2;
      end
      S_RET2: begin
        cmd.mem_asel = MA_SP;
        state_next   = S_RET3;
      end
      S_RET3: begin
        cmd.tmp_load = 1'b1;
        cmd.mem_asel = MA_SP1;
        state_next   = S_RET4;
      end
      S_RET4: begin
        cmd.pc_op  = PC_RET;
        state_next = S_FIN;
      end
      // call: push pc high byte first
      S_CALL1: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_asel = MA_SP;
        cmd.mem_wsel = MW_PCHI;
        state_next   = S_CALL2;
      end
      S_CALL2: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_asel = MA_SP1;
        cmd.mem_wsel = MW_PCLO;
        cmd.sp_op    = SP_INC2;
        cmd.pc_op    = PC_NNN;
        state_next   = S_FIN;
      end
      // bcd store, one digit a cycle
      S_BCD: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_asel = MA_ICNT;
        cmd.mem_wsel = MW_BCD;
        cmd.cnt_op   = CNT_INC;
        if (stat.cnt[1:0] == 2'd2) begin
          cmd.pc_op  = PC_NEXT;
          state_next = S_FIN;
        end
      end
      // register dump
      S_DMPA: begin
        cmd.vr_rsel = VR_CNT;
        state_next  = S_DMPB;
      end
      S_DMPB: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_asel = MA_ICNT;
        cmd.mem_wsel = MW_VQ;
        if (stat.cnt[3:0] == stat.ir[11:8]) begin
          cmd.pc_op  = PC_NEXT;
          state_next = S_FIN;
        end else begin
          cmd.cnt_op = CNT_INC;
          state_next = S_DMPA;
        end
      end
      // register load
      S_LDA: begin
        cmd.mem_asel = MA_ICNT;
        state_next   = S_LDB;
      end
      S_LDB: begin
        cmd.vr_we    = 1'b1;
        cmd.vr_wasel = VA_CNT;
        cmd.vr_wsel  = VW_MEMQ;
        if (stat.cnt[3:0] == stat.ir[11:8]) begin
          cmd.pc_op  = PC_NEXT;
          state_next = S_FIN;
        end else begin
          cmd.cnt_op = CNT_INC;
          state_next = S_LDA;
        end
      end
      // sprite draw: row fetch, then a read-modify-write per set pixel
      S_DR0: begin
        cmd.coll_clr = 1'b1;
        state_next   = (stat.ir[3:0] == 4'd0) ? S_DRF : S_DRR;
      end
      S_DRR: begin
        cmd.mem_asel = MA_ICNT;
        state_next   = S_DRQ;
      end
      S_DRQ: begin
        cmd.row_load = 1'b1;
        if (!stat.clip) begin
          state_next = S_DRB;
        end else if (row_done) begin
          state_next = S_DRF;
        end else begin
          cmd.cnt_op = CNT_INC;
          state_next = S_DRR;
        end
      end
      S_DRB: begin
        if (stat.row_msb) begin
          cmd.mem_asel = MA_PIX;
          state_next   = S_DRW;
        end else begin
          cmd.bit_next = 1'b1;
          if (!stat.bit_last) begin
            state_next = S_DRB;
          end else if (row_done) begin
            state_next = S_DRF;
          end else begin
            cmd.cnt_op = CNT_INC;
            state_next = S_DRR;
          end
        end
      end
      S_DRW: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_asel = MA_PIX;
        cmd.mem_wsel = MW_XOR;
        cmd.coll_upd = 1'b1;
        cmd.bit_next = 1'b1;
        if (!stat.bit_last) begin
          state_next = S_DRB;
        end else if (row_done) begin
          state_next = S_DRF;
        end else begin
          cmd.cnt_op = CNT_INC;
          state_next = S_DRR;
        end
      end
      S_DRF: begin
        cmd.vr_we    = 1'b1;
        cmd.vr_wasel = VA_F;
        cmd.vr_wsel  = VW_COLL;
        cmd.pc_op    = PC_NEXT;
        state_next   = S_FIN;
      end
      // hand the result to the output register once it is free
      S_FIN: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load   = 1'b1;
          cmd.res_status = res;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, status and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      res      <= ST_DONE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      res   <= res_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== src/bytecode_cpu_core.sv =====
// top level of the bytecode cpu core
`timescale 1ns / 1ps
`default_nettype none
// Small 8-bit interpreter core with a 4096-byte memory (program, return stack and the
// 64x32 display bitmap), sixteen byte registers, index register and two timers. Each
// input word is one operation chosen by s_tuser: write byte, read byte, execute one
// instruction, or timer tick; each gives exactly one result word. After reset the core
// runs a clearing pass (memory zeroed, font loaded, registers cleared) before it takes
// the first word. An instruction runs fetch, operand read and execute, then its own
// loop where it has one: flag write for flag-setting arithmetic, display clear, return,
// call, bcd, register dump and register load per register, and sprite draw per row and
// per pixel of each row that is not clipped, with a read-modify-write for each set
// pixel. These sequences follow from the single memory port, one access per cycle, and
// the one-port register file. A new word is accepted while a finished result still
// waits in the output register.
module bytecode_cpu_core
  import bcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // address[11:0], write_data[19:12], random_byte[27:20], keys_down[43:28],
  // key_event_valid[44], key_event_code[48:45]
  input  wire logic [55:0] s_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // read_data[7:0], instruction_word[23:8], program_counter[35:24],
  // key_consumed[36], sound_on[37]
  output logic [39:0]      m_tdata,
  // status[1:0]
  output logic [1:0]       m_tuser
);

  cmd_t  cmd;
  stat_t stat;

  bcc_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bcc_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .stat    (stat),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // no word taken right after reset: the clearing pass runs first
  a_clear_first: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready during clearing pass");

  // one word in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while busy");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  // memory is not written while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.mem_we)
    else $error("memory write while idle");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for the bytecode cpu core
`timescale 1ns / 1ps
module tb_top;
  import bcc_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  bytecode_cpu_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // one operation as the core sees it
  typedef struct {
    logic [1:0]  op;
    logic [11:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  rnd;
    logic [15:0] keys;
    logic        kv;
    logic [3:0]  kcode;
  } op_word_t;

  // expected result word
  typedef struct {
    logic [1:0]  status;
    logic [7:0]  rdata;
    logic [15:0] iword;
    logic [11:0] pc;
    logic        kused;
    logic        snd;
  } cpu_result_t;

  // shadow machine state
  logic [7:0]  sh_mem [0:4095];
  logic [7:0]  sh_v [0:15];
  logic [15:0] sh_i;
  logic [11:0] sh_pc;
  logic [11:0] sh_sp;
  logic [7:0]  sh_dt;
  logic [7:0]  sh_st;

  cpu_result_t pending_results[$];
  int          errors;
  longint      cycles;
  bit          hold_off;
  int          idle_pct;
  int          stall_pct;

  // shadow reset
  task automatic shadow_reset();
    for (int i = 0; i < 4096; i++) sh_mem[i] = 8'h00;
    for (int i = 0; i < FONT_LEN; i++)
      sh_mem[FONT_BASE + i] = FONT_ROM[FONT_LEN*8-1-8*i -: 8];
    for (int i = 0; i < 16; i++) sh_v[i] = 8'h00;
    sh_i  = '0;
    sh_pc = LOAD_BASE;
    sh_sp = STACK_BASE;
    sh_dt = '0;
    sh_st = '0;
  endtask

  // xor sprite into the display bitmap, x wraps, y clips
  function automatic void shadow_draw(input logic [3:0] x, input logic [3:0] y,
                                      input logic [3:0] n);
    int          x0;
    int          y0;
    int          py;
    int          pix;
    logic [7:0]  row;
    logic [11:0] a;
    logic [7:0]  msk;
    x0 = sh_v[x];
    y0 = sh_v[y];
    sh_v[15] = 8'd0;
    for (int i = 0; i < n; i++) begin
      row = sh_mem[12'(sh_i + i)];
      py = y0 + i;
      if (py < 32) begin
        for (int j = 0; j < 8; j++) begin
          if (row[7-j]) begin
            pix = ((x0 + j) % 64) + py * 64;
            a = DISPLAY_BASE + 12'(pix / 8);
            msk = 8'h80 >> (pix % 8);
            if ((sh_mem[a] & msk) != 0) sh_v[15] = 8'd1;
            sh_mem[a] = sh_mem[a] ^ msk;
          end
        end
      end
    end
  endfunction

  // run one instruction on the shadow state, returns status
  function automatic logic [1:0] shadow_exec(input logic [15:0] w, input op_word_t o,
                                             output logic kused);
    logic [3:0]  x;
    logic [3:0]  y;
    logic [7:0]  nn;
    logic [11:0] nxt;
    logic [7:0]  a;
    logic [7:0]  b;
    logic        held;
    x = w[11:8];
    y = w[7:4];
    nn = w[7:0];
    nxt = sh_pc + 12'd2;
    kused = 1'b0;
    case (w[15:12])
      4'h0: begin
        if (w == INS_CLS) begin
          for (int i = 0; i < 256; i++) sh_mem[DISPLAY_BASE + i] = 8'h00;
        end else if (w == INS_RET) begin
          sh_sp = sh_sp - 12'd2;
          nxt = {sh_mem[sh_sp][3:0], sh_mem[12'(sh_sp + 1)]} + 12'd2;
        end else return ST_BAD;
      end
      4'h1: nxt = w[11:0];
      4'h2: begin
        sh_mem[sh_sp] = {4'h0, sh_pc[11:8]};
        sh_mem[12'(sh_sp + 1)] = sh_pc[7:0];
        sh_sp = sh_sp + 12'd2;
        nxt = w[11:0];
      end
      4'h3: if (sh_v[x] == nn) nxt = nxt + 12'd2;
      4'h4: if (sh_v[x] != nn) nxt = nxt + 12'd2;
      4'h5: if (sh_v[x] == sh_v[y]) nxt = nxt + 12'd2;
      4'h6: sh_v[x] = nn;
      4'h7: sh_v[x] = sh_v[x] + nn;
      4'h8: begin
        a = sh_v[x];
        b = sh_v[y];
        case (w[3:0])
          4'h0: sh_v[x] = b;
          4'h1: sh_v[x] = a | b;
          4'h2: sh_v[x] = a & b;
          4'h3: sh_v[x] = a ^ b;
          4'h4: begin sh_v[x] = a + b; sh_v[15] = {7'd0, (9'(a) + 9'(b)) > 9'd255}; end
          4'h5: begin sh_v[x] = a - b; sh_v[15] = {7'd0, a >= b}; end
          4'h6: begin sh_v[x] = a >> 1; sh_v[15] = {7'd0, a[0]}; end
          4'h7: begin sh_v[x] = b - a; sh_v[15] = {7'd0, b >= a}; end
          4'hE: begin sh_v[x] = a << 1; sh_v[15] = {7'd0, a[7]}; end
          default: return ST_BAD;
        endcase
      end
      4'h9: if (sh_v[x] != sh_v[y]) nxt = nxt + 12'd2;
      4'hA: sh_i = {4'h0, w[11:0]};
      4'hB: nxt = 12'(sh_v[0]) + w[11:0];
      4'hC: sh_v[x] = o.rnd & nn;
      4'hD: shadow_draw(x, y, w[3:0]);
      4'hE: begin
        held = (sh_v[x] < 16) && o.keys[sh_v[x][3:0]];
        if (nn == EX_SKP) begin
          if (held) nxt = nxt + 12'd2;
        end else if (nn == EX_SKNP) begin
          if (!held) nxt = nxt + 12'd2;
        end else return ST_BAD;
      end
      default: begin
        case (nn)
          FX_GDT: sh_v[x] = sh_dt;
          FX_KEY: begin
            if (!o.kv) return ST_WAIT;
            sh_v[x] = {4'h0, o.kcode};
            kused = 1'b1;
          end
          FX_SDT: sh_dt = sh_v[x];
          FX_SST: sh_st = sh_v[x];
          FX_ADDI: sh_i = sh_i + 16'(sh_v[x]);
          FX_FONT: sh_i = 16'(FONT_BASE) + 16'(sh_v[x][3:0]) * 16'd5;
          FX_BCD: begin
            a = sh_v[x];
            sh_mem[sh_i[11:0]] = a / 8'd100;
            sh_mem[12'(sh_i + 1)] = (a / 8'd10) % 8'd10;
            sh_mem[12'(sh_i + 2)] = a % 8'd10;
          end
          FX_DUMP: for (int i = 0; i <= x; i++) sh_mem[12'(sh_i + i)] = sh_v[i];
          FX_LOAD: for (int i = 0; i <= x; i++) sh_v[i] = sh_mem[12'(sh_i + i)];
          default: return ST_BAD;
        endcase
      end
    endcase
    sh_pc = nxt;
    return ST_DONE;
  endfunction

  // expected result of one operation
  function automatic cpu_result_t predict_result(input op_word_t o);
    cpu_result_t r;
    r = '{ST_DONE, 8'd0, 16'd0, 12'd0, 1'b0, 1'b0};
    case (o.op)
      OP_WRITE: sh_mem[o.addr] = o.wdata;
      OP_READ:  r.rdata = sh_mem[o.addr];
      OP_EXEC: begin
        r.iword = {sh_mem[sh_pc], sh_mem[12'(sh_pc + 1)]};
        r.status = shadow_exec(r.iword, o, r.kused);
      end
      default: begin
        if (sh_dt != 0) sh_dt = sh_dt - 8'd1;
        if (sh_st != 0) sh_st = sh_st - 8'd1;
      end
    endcase
    r.pc = sh_pc;
    r.snd = (sh_st != 0);
    return r;
  endfunction

  // random gap, mostly short
  function automatic int gap_len(input int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 5);
    return $urandom_range(3, 1);
  endfunction

  // send one word, predict on acceptance
  task automatic send_word(input op_word_t o);
    int g;
    g = gap_len(idle_pct);
    repeat (g) @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  <= o.op;
    s_tdata  <= {7'd0, o.kcode, o.kv, o.keys, o.rnd, o.wdata, o.addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_result(o));
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  function automatic op_word_t mk(input logic [1:0] op, input logic [11:0] addr,
                                  input logic [7:0] wd);
    op_word_t o;
    o.op = op;
    o.addr = addr;
    o.wdata = wd;
    o.rnd = 8'($urandom);
    o.keys = 16'($urandom);
    o.kv = 1'($urandom);
    o.kcode = 4'($urandom);
    return o;
  endfunction

  // load one instruction at pc and run it
  task automatic run_instr(input logic [15:0] w, input logic kv = 1'b0);
    op_word_t o;
    send_word(mk(OP_WRITE, sh_pc, w[15:8]));
    send_word(mk(OP_WRITE, 12'(sh_pc + 1), w[7:0]));
    o = mk(OP_EXEC, 12'($urandom), 8'($urandom));
    o.kv = kv;
    send_word(o);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    cpu_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%h", $realtime, m_tdata, m_tuser);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (m_tuser !== e.status) begin
          $display("%0t: status exp %h got %h", $realtime, e.status, m_tuser); errors++;
        end
        if (m_tdata[7:0] !== e.rdata) begin
          $display("%0t: read_data exp %h got %h", $realtime, e.rdata, m_tdata[7:0]); errors++;
        end
        if (m_tdata[23:8] !== e.iword) begin
          $display("%0t: instruction exp %h got %h", $realtime, e.iword, m_tdata[23:8]);
          errors++;
        end
        if (m_tdata[35:24] !== e.pc) begin
          $display("%0t: pc exp %h got %h", $realtime, e.pc, m_tdata[35:24]); errors++;
        end
        if (m_tdata[36] !== e.kused) begin
          $display("%0t: key_consumed exp %b got %b", $realtime, e.kused, m_tdata[36]);
          errors++;
        end
        if (m_tdata[37] !== e.snd) begin
          $display("%0t: sound_on exp %b got %b", $realtime, e.snd, m_tdata[37]); errors++;
        end
        if (m_tdata[39:38] !== 2'b00) begin
          $display("%0t: pad exp 0 got %b", $realtime, m_tdata[39:38]); errors++;
        end
      end
    end
  end

  // receiver stalls, with one long hold-off on request
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > 64'd3_000_000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // memory write and read back, address extremes and font, plus a timer tick
  task automatic test_memory();
    send_word(mk(OP_READ, FONT_BASE, 8'd0));
    send_word(mk(OP_READ, 12'd79, 8'd0));
    send_word(mk(OP_WRITE, 12'hFFF, 8'hFF));
    send_word(mk(OP_READ, 12'hFFF, 8'd0));
    send_word(mk(OP_WRITE, 12'h000, 8'h00));
    send_word(mk(OP_READ, 12'h000, 8'd0));
    send_word(mk(OP_TICK, 12'd0, 8'd0));
  endtask

  // one of each instruction class and the special cases
  task automatic test_instructions();
    run_instr(16'h00E0);
    run_instr(16'h60FF);
    run_instr(16'h6101);
    run_instr(16'h8014);          // carry out
    run_instr(16'h8F15);          // flag wins when x is f
    run_instr(16'h8017);
    run_instr(16'h80E6);
    run_instr(16'h80EE);
    run_instr(16'h8018);          // unsupported alu form
    run_instr(16'h0123);          // unsupported system call
    run_instr(16'hE0B0);
    run_instr(16'hF0FF);
    run_instr(16'hF00A, 1'b0);    // waits for key
    run_instr(16'hF30A, 1'b1);    // key latched
    run_instr(16'h62FF);
    run_instr(16'hE29E);          // key above 15
    run_instr(16'hE2A1);
    run_instr(16'hF229);
    run_instr(16'hF233);
    run_instr(16'h6A3E);
    run_instr(16'h6B1F);
    run_instr(16'hF11E);
    run_instr(16'hDAB5);          // wraps and clips
    run_instr(16'hDAB0);
    run_instr(16'hF218);
    run_instr(16'hAFFE);
    run_instr(16'hF255);          // dump wraps past top
    run_instr(16'hFF65);
    run_instr(16'h2300);
    run_instr(16'h00EE);
    run_instr(16'hBFFF);
    run_instr(16'h1200);
  endtask

  // random instruction, weighted toward cheap forms
  function automatic logic [15:0] rand_instr();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(19))
      0: w = ($urandom_range(3) == 0) ? INS_CLS : 16'($urandom_range(255));
      1: w = {4'h8, w[11:4], 4'($urandom_range(15))};
      2: w = {4'hE, w[11:8], ($urandom_range(1) ? EX_SKP : EX_SKNP)};
      3, 4: begin
        case ($urandom_range(10))
          0: w[7:0] = FX_GDT;  1: w[7:0] = FX_KEY;  2: w[7:0] = FX_SDT;
          3: w[7:0] = FX_SST;  4: w[7:0] = FX_ADDI; 5: w[7:0] = FX_FONT;
          6: w[7:0] = FX_BCD;  7: w[7:0] = FX_DUMP; 8: w[7:0] = FX_LOAD;
          default: w[7:0] = 8'($urandom);
        endcase
        w[15:12] = 4'hF;
      end
      5: w[15:12] = 4'hD;
      6: w = {4'h2, 12'($urandom_range(4095))};
      7: w = INS_RET;
      default: if (w[15:12] == 4'h0 || w[15:12] == 4'hD) w[15:12] = 4'h6;
    endcase
    return w;
  endfunction

  // random mix: programs with random content, plus plain reads, writes, ticks and executes
  task automatic test_random(input int n);
    int k;
    k = 0;
    while (k < n) begin
      case ($urandom_range(9))
        0: send_word(mk(OP_READ, 12'($urandom), 8'd0));
        1: send_word(mk(OP_READ, DISPLAY_BASE + 12'($urandom_range(255)), 8'd0));
        2: send_word(mk(OP_TICK, 12'($urandom), 8'($urandom)));
        3: send_word(mk(OP_WRITE, 12'($urandom), 8'($urandom)));
        4: send_word(mk(OP_EXEC, 12'($urandom), 8'($urandom)));
        default: begin
          run_instr(rand_instr(), 1'($urandom));
          k += 2;
        end
      endcase
      k++;
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_word(mk(OP_TICK, 12'd0, 8'd0));
    join
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    errors = 0;
    cycles = 0;
    hold_off = 1'b0;
    idle_pct = 30;
    stall_pct = 30;
    shadow_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_memory();
    test_instructions();
    wait_drained();
    test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    test_random(300);
    idle_pct = 40;
    stall_pct = 50;
    test_random(650);
    wait_drained();
    repeat (400) @(negedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== bytecode_cpu_core.f =====
src/bcc_pkg.sv
src/bcc_datapath.sv
src/bcc_controller.sv
src/bytecode_cpu_core.sv
verif/tb_top.sv
